### rtl/ffha_pkg.sv
// Shared constants, types and helpers of the first-fit heap allocator.
package ffha_pkg;

  localparam int MAX_SEGMENTS = 64;
  localparam int HEADER_BYTES = 12;
  localparam int ALIGN_BYTES  = 4;
  localparam int IDX_W        = $clog2(MAX_SEGMENTS);
  localparam int CNT_W        = IDX_W + 1;
  localparam int CFG_IDX_W    = 8;

  localparam logic [31:0] HEAP_BASE_RST  = 32'h0200_0000;
  localparam logic [31:0] HEAP_BYTES_RST = 32'h0400_0000;
  localparam logic [32:0] ALIGN_MASK     = ~33'(ALIGN_BYTES - 1);

  typedef enum logic [1:0] {
    MODE_INIT    = 2'd0,
    MODE_ALLOC   = 2'd1,
    MODE_FREE    = 2'd2,
    MODE_REALLOC = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_UNKNOWN = 2'd2,
    ST_NOTHING = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HEAP_BASE  = 8'd0,
    REG_HEAP_BYTES = 8'd1
  } reg_idx_t;

  typedef struct packed {
    logic [31:0] offset;
    logic [31:0] size;
    logic        free;
  } seg_t;

  localparam int SEG_W = $bits(seg_t);

  // Payload size of the single segment that spans the whole heap.
  function automatic logic [31:0] first_size(input logic [31:0] bytes);
    logic [31:0] hdr;
    hdr = 32'(HEADER_BYTES);
    return (bytes >= hdr) ? (bytes - hdr) : 32'd0;
  endfunction

  // Size of two merged segments, saturated to 32 bits.
  function automatic logic [31:0] merge_size(input logic [31:0] a, input logic [31:0] b);
    logic [33:0] sum;
    sum = {2'b00, a} + {2'b00, b} + 34'(HEADER_BYTES);
    return (sum[33:32] != 2'b00) ? 32'hFFFF_FFFF : sum[31:0];
  endfunction

endpackage

### rtl/ffha_if.sv
// Valid/ready channel interfaces for requests, results and register writes.
interface ffha_in_if;
  import ffha_pkg::*;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [31:0] request_bytes;
  logic [31:0] block_address;
  modport source (output valid, mode, request_bytes, block_address, input ready);
  modport sink (input valid, mode, request_bytes, block_address, output ready);
endinterface

interface ffha_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_address;
  logic [1:0]  status;
  logic [31:0] old_payload_bytes;
  modport source (output valid, result_address, status, old_payload_bytes, input ready);
  modport sink (input valid, result_address, status, old_payload_bytes, output ready);
endinterface

interface ffha_cfg_if;
  import ffha_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [31:0]          data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### rtl/ffha_ram.sv
// Generic RAM with one write port and one registered read port.
module ffha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### rtl/first_fit_heap_allocator.sv
// First-fit heap allocator: the segment table lives in one RAM, walked by a sequencer.
// Init writes one entry spanning the heap; allocate scans segments and shifts entries
// up on a split; free searches segments and moves entries down on a merge. A moving
// reallocate allocates the new block, then searches for and frees the old one.
// One item at a time; the next is taken as soon as the result sits in the output register.
// Reset (synchronous, rst_n low) writes the first table entry in the S_RST state.
module first_fit_heap_allocator
  import ffha_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  ffha_in_if.sink    in_ch,
  ffha_out_if.source out_ch,
  ffha_cfg_if.sink   cfg_ch
);

  typedef enum logic [16:0] {
    S_RST     = 17'h00001,
    S_IDLE    = 17'h00002,
    S_FD_RD   = 17'h00004,
    S_FD_CHK  = 17'h00008,
    S_FR_NRD  = 17'h00010,
    S_FR_NCHK = 17'h00020,
    S_FR_PRD  = 17'h00040,
    S_FR_PCHK = 17'h00080,
    S_DEL_RD  = 17'h00100,
    S_DEL_WR  = 17'h00200,
    S_AL_RD   = 17'h00400,
    S_AL_CHK  = 17'h00800,
    S_SU_RD   = 17'h01000,
    S_SU_WR   = 17'h02000,
    S_SP_WR1  = 17'h04000,
    S_SP_WR0  = 17'h08000,
    S_FIN     = 17'h10000
  } state_t;

  state_t      state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] j_r, j_nxt;
  logic [31:0] req_r, req_nxt;
  logic [31:0] ptr_r, ptr_nxt;
  logic [32:0] rnd_r, rnd_nxt;
  seg_t        cur_r, cur_nxt;
  logic [31:0] res_r, res_nxt;
  status_t     st_r, st_nxt;
  logic [31:0] old_r, old_nxt;
  logic        realloc_r, realloc_nxt;
  logic        move_r, move_nxt;
  logic        del_ret_r, del_ret_nxt;
  logic [31:0] base_r, bytes_r;
  logic        out_valid_r;
  logic [31:0] out_addr_r, out_old_r;
  status_t     out_st_r;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  seg_t             ram_wdata, ram_rdata;
  logic             in_acc, out_load;
  logic [32:0]      req_rnd;

  ffha_ram #(.WIDTH(SEG_W), .DEPTH(MAX_SEGMENTS)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_ch.ready  = (state_r == S_IDLE);
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign req_rnd      = ({1'b0, in_ch.request_bytes} + 33'(ALIGN_BYTES - 1)) & ALIGN_MASK;
  assign out_load     = (state_r == S_FIN) && (!out_valid_r || out_ch.ready);

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    idx_nxt     = idx_r;
    j_nxt       = j_r;
    req_nxt     = req_r;
    ptr_nxt     = ptr_r;
    rnd_nxt     = rnd_r;
    cur_nxt     = cur_r;
    res_nxt     = res_r;
    st_nxt      = st_r;
    old_nxt     = old_r;
    realloc_nxt = realloc_r;
    move_nxt    = move_r;
    del_ret_nxt = del_ret_r;
    ram_we      = 1'b0;
    ram_waddr   = idx_r[IDX_W-1:0];
    ram_wdata   = cur_r;
    ram_raddr   = idx_r[IDX_W-1:0];
    unique case (state_r)
      S_RST: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = '{offset: 32'd0, size: first_size(HEAP_BYTES_RST), free: 1'b1};
        cnt_nxt   = CNT_W'(1);
        state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_acc) begin
          req_nxt     = in_ch.request_bytes;
          ptr_nxt     = in_ch.block_address;
          rnd_nxt     = req_rnd;
          res_nxt     = '0;
          old_nxt     = '0;
          st_nxt      = ST_OK;
          move_nxt    = 1'b0;
          realloc_nxt = 1'b0;
          idx_nxt     = '0;
          unique case (mode_t'(in_ch.mode))
            MODE_INIT: begin
              ram_we    = 1'b1;
              ram_waddr = '0;
              ram_wdata = '{offset: 32'd0, size: first_size(bytes_r), free: 1'b1};
              cnt_nxt   = CNT_W'(1);
              state_nxt = S_FIN;
            end
            MODE_ALLOC: begin
              if (in_ch.request_bytes == 32'd0) begin
                st_nxt    = ST_NOTHING;
                state_nxt = S_FIN;
              end else begin
                state_nxt = S_AL_RD;
              end
            end
            MODE_FREE: begin
              if (in_ch.block_address == 32'd0) begin
                st_nxt    = ST_NOTHING;
                state_nxt = S_FIN;
              end else begin
                state_nxt = S_FD_RD;
              end
            end
            MODE_REALLOC: begin
              if (in_ch.block_address == 32'd0) begin
                if (in_ch.request_bytes == 32'd0) begin
                  st_nxt    = ST_NOTHING;
                  state_nxt = S_FIN;
                end else begin
                  state_nxt = S_AL_RD;
                end
              end else if (in_ch.request_bytes == 32'd0) begin
                state_nxt = S_FD_RD;
              end else begin
                realloc_nxt = 1'b1;
                state_nxt   = S_FD_RD;
              end
            end
            default: state_nxt = S_FIN;
          endcase
        end
      end
      S_FD_RD: begin
        if (idx_r >= cnt_r) begin
          st_nxt    = ST_UNKNOWN;
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_FD_CHK;
        end
      end
      S_FD_CHK: begin
        if (base_r + ram_rdata.offset + 32'(HEADER_BYTES) == ptr_r) begin
          cur_nxt = ram_rdata;
          if (realloc_r) begin
            if (ram_rdata.size >= req_r) begin
              res_nxt   = ptr_r;
              state_nxt = S_FIN;
            end else begin
              old_nxt     = ram_rdata.size;
              move_nxt    = 1'b1;
              realloc_nxt = 1'b0;
              idx_nxt     = '0;
              state_nxt   = S_AL_RD;
            end
          end else begin
            cur_nxt.free = 1'b1;
            state_nxt    = S_FR_NRD;
          end
        end else begin
          idx_nxt   = idx_r + CNT_W'(1);
          state_nxt = S_FD_RD;
        end
      end
      S_FR_NRD: begin
        ram_raddr = IDX_W'(idx_r + CNT_W'(1));
        if (idx_r + CNT_W'(1) < cnt_r) begin
          state_nxt = S_FR_NCHK;
        end else begin
          state_nxt = S_FR_PRD;
        end
      end
      S_FR_NCHK: begin
        if (ram_rdata.free) begin
          cur_nxt.size = merge_size(cur_r.size, ram_rdata.size);
          j_nxt        = idx_r + CNT_W'(1);
          del_ret_nxt  = 1'b1;
          state_nxt    = S_DEL_RD;
        end else begin
          state_nxt = S_FR_PRD;
        end
      end
      S_FR_PRD: begin
        ram_raddr = IDX_W'(idx_r - CNT_W'(1));
        if (idx_r != '0) begin
          state_nxt = S_FR_PCHK;
        end else begin
          ram_we    = 1'b1;
          st_nxt    = ST_OK;
          state_nxt = S_FIN;
        end
      end
      S_FR_PCHK: begin
        if (ram_rdata.free) begin
          // The lower neighbor absorbs this segment, then this entry is removed.
          ram_we      = 1'b1;
          ram_waddr   = IDX_W'(idx_r - CNT_W'(1));
          ram_wdata   = '{offset: ram_rdata.offset,
                          size: merge_size(ram_rdata.size, cur_r.size), free: 1'b1};
          j_nxt       = idx_r;
          del_ret_nxt = 1'b0;
          state_nxt   = S_DEL_RD;
        end else begin
          ram_we    = 1'b1;
          st_nxt    = ST_OK;
          state_nxt = S_FIN;
        end
      end
      S_DEL_RD: begin
        ram_raddr = IDX_W'(j_r + CNT_W'(1));
        if (j_r + CNT_W'(1) < cnt_r) begin
          state_nxt = S_DEL_WR;
        end else begin
          cnt_nxt = cnt_r - CNT_W'(1);
          if (del_ret_r) begin
            state_nxt = S_FR_PRD;
          end else begin
            st_nxt    = ST_OK;
            state_nxt = S_FIN;
          end
        end
      end
      S_DEL_WR: begin
        ram_we    = 1'b1;
        ram_waddr = j_r[IDX_W-1:0];
        ram_wdata = ram_rdata;
        j_nxt     = j_r + CNT_W'(1);
        state_nxt = S_DEL_RD;
      end
      S_AL_RD: begin
        if (idx_r >= cnt_r) begin
          // A failed move leaves the old block in place.
          st_nxt    = ST_NOSPACE;
          res_nxt   = '0;
          old_nxt   = '0;
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_AL_CHK;
        end
      end
      S_AL_CHK: begin
        if (ram_rdata.free && ({1'b0, ram_rdata.size} >= rnd_r)) begin
          cur_nxt = ram_rdata;
          res_nxt = base_r + ram_rdata.offset + 32'(HEADER_BYTES);
          if (({2'b00, ram_rdata.size} >
               ({1'b0, rnd_r} + 34'(HEADER_BYTES + ALIGN_BYTES))) &&
              (cnt_r < CNT_W'(MAX_SEGMENTS))) begin
            j_nxt     = cnt_r;
            state_nxt = S_SU_RD;
          end else begin
            ram_we    = 1'b1;
            ram_wdata = '{offset: ram_rdata.offset, size: ram_rdata.size, free: 1'b0};
            if (move_r) begin
              idx_nxt   = '0;
              state_nxt = S_FD_RD;
            end else begin
              st_nxt    = ST_OK;
              state_nxt = S_FIN;
            end
          end
        end else begin
          idx_nxt   = idx_r + CNT_W'(1);
          state_nxt = S_AL_RD;
        end
      end
      S_SU_RD: begin
        ram_raddr = IDX_W'(j_r - CNT_W'(1));
        if (j_r > idx_r + CNT_W'(1)) begin
          state_nxt = S_SU_WR;
        end else begin
          state_nxt = S_SP_WR1;
        end
      end
      S_SU_WR: begin
        ram_we    = 1'b1;
        ram_waddr = j_r[IDX_W-1:0];
        ram_wdata = ram_rdata;
        j_nxt     = j_r - CNT_W'(1);
        state_nxt = S_SU_RD;
      end
      S_SP_WR1: begin
        ram_we    = 1'b1;
        ram_waddr = IDX_W'(idx_r + CNT_W'(1));
        ram_wdata = '{offset: cur_r.offset + 32'(HEADER_BYTES) + rnd_r[31:0],
                      size: cur_r.size - rnd_r[31:0] - 32'(HEADER_BYTES), free: 1'b1};
        cnt_nxt   = cnt_r + CNT_W'(1);
        state_nxt = S_SP_WR0;
      end
      S_SP_WR0: begin
        ram_we    = 1'b1;
        ram_wdata = '{offset: cur_r.offset, size: rnd_r[31:0], free: 1'b0};
        if (move_r) begin
          idx_nxt   = '0;
          state_nxt = S_FD_RD;
        end else begin
          st_nxt    = ST_OK;
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_RST;
      cnt_r       <= CNT_W'(1);
      out_valid_r <= 1'b0;
      base_r      <= HEAP_BASE_RST;
      bytes_r     <= HEAP_BYTES_RST;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        if (cfg_ch.index == REG_HEAP_BASE) begin
          base_r <= cfg_ch.data;
        end else if (cfg_ch.index == REG_HEAP_BYTES) begin
          bytes_r <= cfg_ch.data;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r     <= idx_nxt;
    j_r       <= j_nxt;
    req_r     <= req_nxt;
    ptr_r     <= ptr_nxt;
    rnd_r     <= rnd_nxt;
    cur_r     <= cur_nxt;
    res_r     <= res_nxt;
    st_r      <= st_nxt;
    old_r     <= old_nxt;
    realloc_r <= realloc_nxt;
    move_r    <= move_nxt;
    del_ret_r <= del_ret_nxt;
    if (out_load) begin
      out_addr_r <= res_r;
      out_st_r   <= st_r;
      out_old_r  <= old_r;
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.result_address    = out_addr_r;
  assign out_ch.status            = out_st_r;
  assign out_ch.old_payload_bytes = out_old_r;

`ifndef NO_ASSERTIONS
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != '0) && (cnt_r <= CNT_W'(MAX_SEGMENTS)))
    else $error("segment count out of range");
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r != S_IDLE))
    else $error("sequencer stayed idle after taking a beat");
  a_write_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> ({1'b0, ram_waddr} <= cnt_r))
    else $error("table write beyond the used entries");
  a_load_only_at_fin: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (state_r == S_IDLE) && out_valid_r)
    else $error("result loaded without returning to idle");
`endif

endmodule
